// File: design/sbp_pkg.sv
`default_nettype none
package sbp_pkg;

   localparam int SCREEN_WIDTH = 72;
   localparam int SCREEN_PAGES = 5;
   localparam int SCREEN_ROWS  = SCREEN_PAGES * 8;
   localparam int STORE_SIZE   = SCREEN_WIDTH * SCREEN_PAGES;
   localparam int STORE_AW     = $clog2(STORE_SIZE);
   localparam int COL_W        = $clog2(SCREEN_WIDTH);
   localparam int PAGE_W       = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;

   localparam int REQ_W      = 2;
   localparam int ADDR_W     = 9;
   localparam int DATA_W     = 8;
   localparam int CNT_W      = 7;
   localparam int SIZE_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [SIZE_W-1:0] SIZE_MAX = 8'd128;

   localparam logic [CSR_IDX_W-1:0] CSR_DEST_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_W  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_H  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_AXES = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_X  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_Y  = 3'd6;

   typedef enum logic [REQ_W-1:0] {
      OP_PIXEL = 2'd0,
      OP_LOAD  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_READ  = 1'b1
   } kind_type;

endpackage
`default_nettype wire

// File: design/sbp_req_if.sv
`default_nettype none
interface sbp_req_if
   import sbp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic              luma;
   logic              alpha;
   logic [ADDR_W-1:0] fb_address;
   logic [DATA_W-1:0] fb_data;

   modport source (output valid, req_type, luma, alpha, fb_address, fb_data, input ready);
   modport sink (input valid, req_type, luma, alpha, fb_address, fb_data, output ready);
endinterface
`default_nettype wire

// File: design/sbp_rsp_if.sv
`default_nettype none
interface sbp_rsp_if
   import sbp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   kind_type          out_kind;
   logic [ADDR_W-1:0] out_address;
   logic [DATA_W-1:0] out_data;
   logic              sprite_end;

   modport source (output valid, out_kind, out_address, out_data, sprite_end, input ready);
   modport sink (input valid, out_kind, out_address, out_data, sprite_end, output ready);
endinterface
`default_nettype wire

// File: design/sprite_blit_page_framebuffer.sv
// Sprite blitter into a page-organized 1-bit framebuffer kept in on-chip memory.
// Requests arrive on req_chan: a sprite pixel (luma, alpha) in source raster
// order, a byte load, or a byte read. Each drawn pixel and each read gives one
// response on rsp_chan with the byte address and its new or current contents;
// sprite_end marks the last pixel of the sprite. Transparent or off-screen
// pixels, loads and unknown request codes give no response.
// The csr_ port writes the placement, size and mirror/transpose controls at
// any time; change them only while no request is in flight.
// An accepted request passes through stage A, stage B and the output register.
// Throughput: one request per cycle unless the receiver stalls. The framebuffer
// memory has one read and one write port; a read-modify-write takes the read in
// one stage and the write in the next, with the last written byte forwarded to
// the modify step. After reset the block clears the framebuffer one byte a
// cycle, all STORE_SIZE (360) bytes, with req_chan.ready low.
// When the receiver stalls, the output register holds its response and the
// two internal stages take up to two more responding requests before ready drops.
`default_nettype none
module sprite_blit_page_framebuffer
   import sbp_pkg::*;
   (
   input  wire                  clock,
   input  wire                  reset,
   sbp_req_if.sink              req_chan,
   sbp_rsp_if.source            rsp_chan,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0] csr_wdata
   );

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] r;
      r = s;
      if (s == '0) r = SIZE_W'(1);
      else if (s > SIZE_MAX) r = SIZE_MAX;
      return r;
   endfunction

   // Configuration registers.
   logic [7:0]        dest_x_ff, dest_y_ff;
   logic [SIZE_W-1:0] sprite_w_ff, sprite_h_ff;
   logic              swap_axes_ff, mirror_x_ff, mirror_y_ff;

   // Source counters and clearing pass.
   logic [CNT_W-1:0]    col_ff, col_in, row_ff, row_in;
   logic                clearing_ff;
   logic [STORE_AW-1:0] clr_cnt_ff;

   // Stage A: decoded request.
   logic              a_valid_ff;
   op_type            a_op_ff;
   logic              a_hit_ff, a_luma_ff, a_end_ff;
   logic [ADDR_W-1:0] a_addr_ff;
   logic [DATA_W-1:0] a_data_ff;
   logic [COL_W-1:0]  a_col_ff;
   logic [PAGE_W-1:0] a_page_ff;
   logic [2:0]        a_bit_ff;

   // Stage B: memory data available, modify and write.
   logic                b_valid_ff;
   op_type              b_op_ff;
   logic                b_hit_ff, b_luma_ff, b_end_ff;
   logic [ADDR_W-1:0]   b_addr_ff;
   logic [DATA_W-1:0]   b_data_ff;
   logic [STORE_AW-1:0] b_idx_ff;
   logic [2:0]          b_bit_ff;
   logic [DATA_W-1:0]   rd_data_ff;

   // Last byte written, forwarded to the modify step.
   logic                lw_valid_ff;
   logic [STORE_AW-1:0] lw_idx_ff;
   logic [DATA_W-1:0]   lw_data_ff;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   kind_type          out_kind_ff;
   logic [ADDR_W-1:0] out_addr_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic              out_end_ff;

   logic [DATA_W-1:0] frame_mem [STORE_SIZE];

   logic [SIZE_W-1:0] w_eff, h_eff;
   logic [SIZE_W-1:0] col_inc, row_inc;
   logic              col_wrap, row_wrap;
   logic [8:0]        sx, sy, tx, ty;
   logic [9:0]        px, py;
   logic              x_ok, y_ok;
   op_type            req_op;
   logic              req_fire, req_hit;

   logic                a_adv, a_free, b_adv, b_free, b_res, b_we, rsp_fire;
   logic [STORE_AW-1:0] a_idx;
   logic [DATA_W-1:0]   base, mask, pix_new, b_wdata;
   logic                mem_we;
   logic [STORE_AW-1:0] mem_widx;
   logic [DATA_W-1:0]   mem_wdata;

   // Handshake and pipeline flow.
   always_comb begin
      rsp_fire = out_valid_ff && rsp_chan.ready;
      b_res    = (b_op_ff == OP_READ) || (b_op_ff == OP_PIXEL && b_hit_ff);
      b_adv    = b_valid_ff && (!b_res || !out_valid_ff || rsp_chan.ready);
      b_free   = !b_valid_ff || b_adv;
      a_adv    = a_valid_ff && b_free;
      a_free   = !a_valid_ff || a_adv;
   end

   assign req_chan.ready = !clearing_ff && a_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_op         = op_type'(req_chan.req_type);

   // Source position and screen transform.
   always_comb begin
      w_eff    = eff_size(sprite_w_ff);
      h_eff    = eff_size(sprite_h_ff);
      col_inc  = {1'b0, col_ff} + SIZE_W'(1);
      row_inc  = {1'b0, row_ff} + SIZE_W'(1);
      col_wrap = col_inc >= w_eff;
      row_wrap = col_wrap && (row_inc >= h_eff);
      col_in   = col_wrap ? '0 : col_inc[CNT_W-1:0];
      row_in   = col_wrap ? (row_wrap ? '0 : row_inc[CNT_W-1:0]) : row_ff;

      // A counter left beyond the size by a register change mirrors to a
      // negative offset, so the source coordinates are two's complement.
      sx = mirror_x_ff ? ({1'b0, w_eff} - 9'd1 - {2'b0, col_ff}) : {2'b0, col_ff};
      sy = mirror_y_ff ? ({1'b0, h_eff} - 9'd1 - {2'b0, row_ff}) : {2'b0, row_ff};
      tx = swap_axes_ff ? sy : sx;
      ty = swap_axes_ff ? sx : sy;
      px = {{2{dest_x_ff[7]}}, dest_x_ff} + {tx[8], tx};
      py = {{2{dest_y_ff[7]}}, dest_y_ff} + {ty[8], ty};
      x_ok = !px[9] && (px < 10'(SCREEN_WIDTH));
      y_ok = !py[9] && (py < 10'(SCREEN_ROWS));

      case (req_op)
         OP_PIXEL: req_hit = req_chan.alpha && x_ok && y_ok;
         OP_LOAD,
         OP_READ:  req_hit = 32'(req_chan.fb_address) < STORE_SIZE;
         default:  req_hit = 1'b0;
      endcase
   end

   // Memory index for stage A; out-of-range requests read entry zero harmlessly.
   always_comb begin
      if (!a_hit_ff) a_idx = '0;
      else if (a_op_ff == OP_PIXEL)
         a_idx = STORE_AW'(a_page_ff * SCREEN_WIDTH) + STORE_AW'(a_col_ff);
      else a_idx = STORE_AW'(a_addr_ff);
   end

   // Modify step.
   always_comb begin
      base    = (lw_valid_ff && lw_idx_ff == b_idx_ff) ? lw_data_ff : rd_data_ff;
      mask    = DATA_W'(1) << b_bit_ff;
      pix_new = b_luma_ff ? (base | mask) : (base & ~mask);
      b_wdata = (b_op_ff == OP_LOAD) ? b_data_ff : pix_new;
      b_we    = b_adv && b_hit_ff && (b_op_ff == OP_PIXEL || b_op_ff == OP_LOAD);

      mem_we    = clearing_ff || b_we;
      mem_widx  = clearing_ff ? clr_cnt_ff : b_idx_ff;
      mem_wdata = clearing_ff ? '0 : b_wdata;

      if (b_adv && b_res) out_valid_in = 1'b1;
      else if (rsp_fire) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) frame_mem[mem_widx] <= mem_wdata;
      if (a_adv) rd_data_ff <= frame_mem[a_idx];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff    <= '0;
         dest_y_ff    <= '0;
         sprite_w_ff  <= SIZE_W'(8);
         sprite_h_ff  <= SIZE_W'(8);
         swap_axes_ff <= 1'b0;
         mirror_x_ff  <= 1'b0;
         mirror_y_ff  <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         lw_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEST_X:    dest_x_ff    <= csr_wdata;
               CSR_DEST_Y:    dest_y_ff    <= csr_wdata;
               CSR_SPRITE_W:  sprite_w_ff  <= csr_wdata;
               CSR_SPRITE_H:  sprite_h_ff  <= csr_wdata;
               CSR_SWAP_AXES: swap_axes_ff <= csr_wdata[0];
               CSR_MIRROR_X:  mirror_x_ff  <= csr_wdata[0];
               CSR_MIRROR_Y:  mirror_y_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + STORE_AW'(1);
            if (clr_cnt_ff == STORE_AW'(STORE_SIZE - 1)) clearing_ff <= 1'b0;
         end
         if (req_fire && req_op == OP_PIXEL) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (a_free) a_valid_ff <= req_fire;
         if (b_free) b_valid_ff <= a_adv;
         if (b_we) lw_valid_ff <= 1'b1;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_op_ff   <= req_op;
         a_hit_ff  <= req_hit;
         a_luma_ff <= req_chan.luma;
         a_end_ff  <= row_wrap;
         a_addr_ff <= req_chan.fb_address;
         a_data_ff <= req_chan.fb_data;
         a_col_ff  <= px[COL_W-1:0];
         a_page_ff <= py[PAGE_W+2:3];
         a_bit_ff  <= py[2:0];
      end
      if (a_adv) begin
         b_op_ff   <= a_op_ff;
         b_hit_ff  <= a_hit_ff;
         b_luma_ff <= a_luma_ff;
         b_end_ff  <= a_end_ff;
         b_addr_ff <= a_addr_ff;
         b_data_ff <= a_data_ff;
         b_idx_ff  <= a_idx;
         b_bit_ff  <= a_bit_ff;
      end
      if (b_we) begin
         lw_idx_ff  <= b_idx_ff;
         lw_data_ff <= b_wdata;
      end
      if (b_adv && b_res) begin
         if (b_op_ff == OP_READ) begin
            out_kind_ff <= KIND_READ;
            out_addr_ff <= b_addr_ff;
            out_data_ff <= b_hit_ff ? base : '0;
            out_end_ff  <= 1'b0;
         end else begin
            out_kind_ff <= KIND_PIXEL;
            out_addr_ff <= ADDR_W'(b_idx_ff);
            out_data_ff <= pix_new;
            out_end_ff  <= b_end_ff;
         end
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_kind    = out_kind_ff;
   assign rsp_chan.out_address = out_addr_ff;
   assign rsp_chan.out_data    = out_data_ff;
   assign rsp_chan.sprite_end  = out_end_ff;

endmodule
`default_nettype wire
